// ===== hw/rtl/gaqs_pkg.sv =====
// Package for the gas air quality score block: states, constants, 2^x table.
package gaqs_pkg;

	localparam int EXP_TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int P_W = 16 + IDX_W;

	localparam logic [63:0] LN2_Q30 = 64'd744261118;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	localparam int LOG2E_Q16 = 94548;
	localparam logic [27:0] ZNUM_K = 28'(1762 * LOG2E_Q16);
	localparam logic [16:0] LOG2E_K = 17'(LOG2E_Q16);
	localparam logic [6:0] ZDEN_K = 7'd100;
	localparam int Z_OFS = 24312;
	localparam int H_OFS = 27315;
	localparam logic [15:0] HDEN_K = 16'd46152;
	localparam logic [15:0] N_K = 16'd61120;
	localparam logic [14:0] SCORE_K = 15'd25600;
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

	localparam logic [7:0] BURN_IN_RST = 8'd25;
	localparam logic [15:0] GAIN_RST = 16'd1966;

	localparam logic REG_BURN_IN = 1'b0;
	localparam logic REG_GAIN = 1'b1;

	typedef logic [31:0] exp_tab_t [0:EXP_TABLE_DEPTH];

	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		logic [63:0] u;
		logic [63:0] s;
		logic [63:0] term;
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			u = (64'(i) * LN2_Q30) / EXP_TABLE_DEPTH;
			s = ONE_Q30;
			term = ONE_Q30;
			for (int k = 1; k <= 24; k++) begin
				term = ((term * u) >> 30) / 64'(k);
				s = s + term;
			end
			tab[i] = s[31:0];
		end
		tab[EXP_TABLE_DEPTH] = 32'h8000_0000;
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ZPREP,
		ST_ZDIV_GO,
		ST_ZDIV_WAIT,
		ST_XPOW_A,
		ST_XPOW_B,
		ST_NMUL,
		ST_NSHIFT,
		ST_HDIV_GO,
		ST_HDIV_WAIT,
		ST_YMUL1,
		ST_YMUL2,
		ST_YPOW_A,
		ST_YPOW_B,
		ST_CMUL,
		ST_CSHIFT,
		ST_UPDATE,
		ST_NORM,
		ST_RDIV_GO,
		ST_RDIV_WAIT,
		ST_SMUL1,
		ST_SMUL2,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quot;
	} div_rsp_t;

endpackage

// ===== hw/rtl/gaqs_div.sv =====
// Shared restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
module gaqs_div (
	input  logic                clk,
	input  logic                arst_n,
	input  gaqs_pkg::div_req_t  req,
	output gaqs_pkg::div_rsp_t  rsp
);
	import gaqs_pkg::*;

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] den_q;

	logic [32:0] rem_sh;
	logic        ge;
	logic [32:0] rem_nx;

	always_comb begin
		rem_sh = {rem_q, quo_q[63]};
		ge = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= rem_nx[31:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// ===== hw/rtl/gaqs_pow2.sv =====
// 2^f mantissa for a Q16 fraction: table lookup then linear interpolation, Q30 result.
module gaqs_pow2 (
	input  logic        clk,
	input  logic        load,
	input  logic [15:0] frac,
	output logic [31:0] mant
);
	import gaqs_pkg::*;

	logic [P_W-1:0]   p;
	logic [IDX_W-1:0] idx;
	logic [IDX_W-1:0] idx_n;
	logic [31:0]      ei_q;
	logic [31:0]      ed_q;
	logic [15:0]      r_q;
	logic [47:0]      prod;

	always_comb begin
		p = P_W'(frac) * P_W'(EXP_TABLE_DEPTH);
		idx = p[P_W-1:16];
		idx_n = idx + IDX_W'(1);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ei_q <= EXP_TAB[idx];
			ed_q <= EXP_TAB[idx_n] - EXP_TAB[idx];
			r_q <= p[15:0];
		end
	end

	always_comb begin
		prod = 48'(ed_q) * 48'(r_q);
		mant = ei_q + prod[47:16];
	end

endmodule

// ===== hw/rtl/gas_air_quality_score.sv =====
// Top level: sequencer and datapath of the humidity-compensated gas air quality score.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata: gas_ohms, humidity_milli, temp_centi
//  m_*      out  m_tvalid/m_tready  m_tdata: score_q8; m_tuser: score_valid, ceiling_raised
//  cfg_*    in   cfg_we             cfg_index, cfg_data
//
// A reading runs the shared 64-step divider twice during burn-in or while the gas ceiling
// stays zero, and three times after it, with the normalize loop ahead of the third run.
// s_tready is high only while the sequencer is idle. A finished result waits in the output
// register and does not block the next request, but the sequencer holds in its last state
// while the output register is still full.
// Reset clears the burn-in count, the gas ceiling and the registers to defaults.
module gas_air_quality_score (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // gas_ohms[23:0], humidity_milli[40:24], temp_centi[55:41]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // score_q8[14:0], zero[15]
	output logic [1:0]  m_tuser,   // score_valid[0], ceiling_raised[1]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import gaqs_pkg::*;

	state_t state_q, state_d;

	logic [7:0]  burn_len_q;
	logic [15:0] gain_q;
	logic [7:0]  burn_cnt_q;
	logic [47:0] ceil_q;

	logic [23:0] gas_q;
	logic [16:0] hum_q;
	logic signed [14:0] temp_q;

	logic [42:0] zmag_q;
	logic        zneg_q;
	logic [21:0] zden_q;
	logic signed [23:0] zx_q;
	logic [31:0] hden_q;
	logic [32:0] hk_q;
	logic [31:0] m_q;
	logic signed [7:0] ipx_q;
	logic [63:0] n_q;
	logic [39:0] hq_q;
	logic [39:0] gq_q;
	logic [47:0] zy_q;
	logic [31:0] ipy_q;
	logic [55:0] q_q;
	logic [47:0] c_q;
	logic [47:0] cc_q;
	logic [47:0] ce_q;
	logic [16:0] rq_q;
	logic [33:0] sq_q;

	logic [14:0] score_r_q;
	logic        valid_r_q;
	logic        raised_r_q;

	logic        out_valid_q;
	logic [14:0] out_score_q;
	logic        out_valid_f_q;
	logic        out_raised_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic        pow_load;
	logic [15:0] pow_frac;
	logic [31:0] pow_mant;
	logic        out_load;

	gaqs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	gaqs_pow2 u_pow2 (
		.clk  (clk),
		.load (pow_load),
		.frac (pow_frac),
		.mant (pow_mant)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (s_tvalid) state_d = ST_ZPREP;
			ST_ZPREP:     state_d = ST_ZDIV_GO;
			ST_ZDIV_GO:   state_d = ST_ZDIV_WAIT;
			ST_ZDIV_WAIT: if (div_rsp.done) state_d = ST_XPOW_A;
			ST_XPOW_A:    state_d = ST_XPOW_B;
			ST_XPOW_B:    state_d = ST_NMUL;
			ST_NMUL:      state_d = ST_NSHIFT;
			ST_NSHIFT:    state_d = ST_HDIV_GO;
			ST_HDIV_GO:   state_d = ST_HDIV_WAIT;
			ST_HDIV_WAIT: if (div_rsp.done) state_d = ST_YMUL1;
			ST_YMUL1:     state_d = ST_YMUL2;
			ST_YMUL2:     state_d = ST_YPOW_A;
			ST_YPOW_A:    state_d = ST_YPOW_B;
			ST_YPOW_B:    state_d = ST_CMUL;
			ST_CMUL:      state_d = ST_CSHIFT;
			ST_CSHIFT:    state_d = ST_UPDATE;
			ST_UPDATE: begin
				if (burn_cnt_q < burn_len_q) state_d = ST_OUT;
				else if (c_q > ceil_q || ceil_q != '0) state_d = ST_NORM;
				else state_d = ST_OUT;
			end
			ST_NORM:      if (ce_q[47:32] == '0) state_d = ST_RDIV_GO;
			ST_RDIV_GO:   state_d = ST_RDIV_WAIT;
			ST_RDIV_WAIT: if (div_rsp.done) state_d = ST_SMUL1;
			ST_SMUL1:     state_d = ST_SMUL2;
			ST_SMUL2:     state_d = ST_OUT;
			ST_OUT:       if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = 1'b0;
		pow_load = 1'b0;
		pow_frac = zx_q[15:0];
		out_load = 1'b0;
		div_req.start = 1'b0;
		div_req.num = {16'd0, cc_q[31:0], 16'd0};
		div_req.den = ce_q[31:0];
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_ZDIV_GO: begin
				div_req.start = 1'b1;
				div_req.num = 64'(zmag_q);
				div_req.den = 32'(zden_q);
			end
			ST_XPOW_A: pow_load = 1'b1;
			ST_HDIV_GO: begin
				div_req.start = 1'b1;
				div_req.num = n_q;
				div_req.den = hden_q;
			end
			ST_YPOW_A: begin
				pow_load = 1'b1;
				pow_frac = zy_q[15:0];
			end
			ST_RDIV_GO: div_req.start = 1'b1;
			ST_OUT: out_load = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burn_len_q <= BURN_IN_RST;
			gain_q <= GAIN_RST;
			burn_cnt_q <= '0;
			ceil_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BURN_IN: burn_len_q <= cfg_data[7:0];
					REG_GAIN:    gain_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_UPDATE) begin
				if (burn_cnt_q < burn_len_q) burn_cnt_q <= burn_cnt_q + 8'd1;
				else if (c_q > ceil_q) ceil_q <= c_q;
			end
		end
	end

	// datapath
	logic [14:0] t_abs;
	logic signed [16:0] zs;
	logic signed [16:0] hs;
	logic [23:0] zpos;
	logic [7:0]  ipneg;
	logic [55:0] gq_full;
	logic [56:0] zy_full;
	logic [55:0] c_right;
	logic [31:0] s_left;
	logic [47:0] c_next;
	logic [47:0] ceil_next;
	logic [48:0] sc_full;

	always_comb begin
		t_abs = temp_q[14] ? 15'(-temp_q) : 15'(temp_q);
		zs = 17'(Z_OFS) + 17'(temp_q);
		hs = 17'(H_OFS) + 17'(temp_q);
		zpos = {1'b0, div_rsp.quot[22:0]};
		ipneg = 8'(-ipx_q);
		gq_full = 56'(gain_q) * 56'(hq_q);
		zy_full = 57'(gq_q) * 57'(LOG2E_K);
		c_right = q_q >> (5'(6'd30 - 6'(ipy_q[4:0])));
		s_left = ipy_q - 32'd30;
		if (ipy_q < 32'd30) begin
			c_next = (c_right[55:48] != '0) ? MAX48 : c_right[47:0];
		end else if (q_q == '0) begin
			c_next = '0;
		end else if (s_left >= 32'd48) begin
			c_next = MAX48;
		end else if ((q_q >> (6'(6'd48 - s_left[5:0]))) != '0) begin
			c_next = MAX48;
		end else begin
			c_next = 48'(q_q << s_left[5:0]);
		end
		ceil_next = (c_q > ceil_q) ? c_q : ceil_q;
		sc_full = 49'(sq_q) * 49'(SCORE_K);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				gas_q <= s_tdata[23:0];
				hum_q <= s_tdata[40:24];
				temp_q <= s_tdata[55:41];
			end
			ST_ZPREP: begin
				zmag_q <= 43'(t_abs) * 43'(ZNUM_K);
				zneg_q <= temp_q[14];
				zden_q <= 22'(zs[15:0]) * 22'(ZDEN_K);
			end
			ST_ZDIV_WAIT: zx_q <= zneg_q ? (24'sd0 - $signed(zpos)) : $signed(zpos);
			ST_XPOW_A: hden_q <= 32'(hs[15:0]) * 32'(HDEN_K);
			ST_XPOW_B: begin
				m_q <= pow_mant;
				ipx_q <= zx_q[23:16];
				hk_q <= 33'(hum_q) * 33'(N_K);
			end
			ST_NMUL: n_q <= 64'(51'(hk_q) * 51'(m_q[31:14]));
			ST_NSHIFT: begin
				if (!ipx_q[7]) n_q <= n_q << ipx_q[6:0];
				else if (ipneg >= 8'd64) n_q <= '0;
				else n_q <= n_q >> ipneg[5:0];
			end
			ST_HDIV_WAIT: hq_q <= div_rsp.quot[39:0];
			ST_YMUL1: gq_q <= gq_full[55:16];
			ST_YMUL2: zy_q <= 48'(zy_full[56:16]);
			ST_YPOW_B: begin
				m_q <= pow_mant;
				ipy_q <= zy_q[47:16];
			end
			ST_CMUL: q_q <= 56'(gas_q) * 56'(m_q);
			ST_CSHIFT: c_q <= c_next;
			ST_UPDATE: begin
				cc_q <= c_q;
				ce_q <= ceil_next;
				if (burn_cnt_q < burn_len_q) begin
					score_r_q <= '0;
					valid_r_q <= 1'b0;
					raised_r_q <= 1'b0;
				end else begin
					score_r_q <= SCORE_K;
					valid_r_q <= 1'b1;
					raised_r_q <= c_q > ceil_q;
				end
			end
			ST_NORM: begin
				if (ce_q[47:32] != '0) begin
					cc_q <= cc_q >> 1;
					ce_q <= ce_q >> 1;
				end
			end
			ST_RDIV_WAIT: rq_q <= div_rsp.quot[16:0];
			ST_SMUL1: sq_q <= 34'(rq_q) * 34'(rq_q);
			ST_SMUL2: score_r_q <= sc_full[46:32];
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_score_q <= score_r_q;
			out_valid_f_q <= valid_r_q;
			out_raised_q <= raised_r_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, out_score_q};
	assign m_tuser = {out_raised_q, out_valid_f_q};

	a_burn_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 16'd0 && !m_tuser[1])
		else $error("burn-in result carries a score or a raise");

	a_score_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata <= 16'(SCORE_K))
		else $error("score above 100 percent");

	a_raise_ceil: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> ceil_q != '0)
		else $error("raise reported with a zero ceiling");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_ZDIV_WAIT || state_q == ST_HDIV_WAIT
			|| state_q == ST_RDIV_WAIT)
		else $error("divider finished outside a wait state");

endmodule

// ===== dv/tb_gas_air_quality_score.sv =====
// Testbench for gas_air_quality_score: random and directed readings checked against a score predictor.
module tb_gas_air_quality_score;
	timeunit 1ns;
	timeprecision 1ps;

	import gaqs_pkg::*;

	localparam int LIMIT = 2000000;
	localparam int DRAIN = 400;
	localparam longint unsigned SAT48 = 64'hFFFF_FFFF_FFFF;

	typedef struct {
		logic [23:0] gas;
		logic [16:0] hum;
		logic [14:0] temp;
	} reading_t;

	typedef struct {
		logic [15:0] score;
		logic        valid;
		logic        raised;
	} score_t;

	class aq_score_tracker;
		longint unsigned pow_tab [0:EXP_TABLE_DEPTH];
		logic [7:0]  burn_len;
		logic [15:0] gain;
		logic [7:0]  burn_cnt;
		longint unsigned ceiling;
		score_t      expected_scores[$];
		int          mismatches;

		function new();
			longint unsigned u, acc, term;
			for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
				u = (longint'(i) * 64'd744261118) / EXP_TABLE_DEPTH;
				acc = 64'd1 << 30;
				term = 64'd1 << 30;
				for (int k = 1; k <= 24; k++) begin
					term = ((term * u) >> 30) / k;
					acc += term;
				end
				pow_tab[i] = acc;
			end
			pow_tab[EXP_TABLE_DEPTH] = 64'd1 << 31;
			burn_len = BURN_IN_RST;
			gain = GAIN_RST;
			burn_cnt = 0;
			ceiling = 0;
			mismatches = 0;
		endfunction

		function void set_reg(logic idx, logic [15:0] val);
			if (idx == REG_BURN_IN)
				burn_len = val[7:0];
			else
				gain = val;
		endfunction

		// 2^z, z in Q16: Q30 mantissa, integer part in ip
		function longint unsigned exp2_q16(longint z, output longint ip);
			longint unsigned f, p, i, r;
			f = longint'(z) & 64'hFFFF;
			p = f * EXP_TABLE_DEPTH;
			i = p >> 16;
			r = p & 64'hFFFF;
			ip = (z - longint'(f)) / 65536;
			return pow_tab[i] + (((pow_tab[i+1] - pow_tab[i]) * r) >> 16);
		endfunction

		function void note_reading(reading_t rd);
			longint t, zx, zy, ip, sh;
			longint unsigned h, g, m, n, hq, zyu, q, c, cc, ce, rq;
			score_t e;
			t = longint'($signed(rd.temp));
			h = rd.hum;
			g = rd.gas;
			e = '{16'd0, 1'b0, 1'b0};
			zx = (longint'(1762) * t * 94548) / (longint'(100) * (24312 + t));
			m = exp2_q16(zx, ip);
			n = h * 64'd61120 * (m >> 14);
			if (ip >= 0)
				n = n << ip;
			else if (-ip >= 64)
				n = 0;
			else
				n = n >> (-ip);
			hq = n / (64'd46152 * longint'(27315 + t));
			zyu = (((longint'(gain) * hq) >> 16) * 64'd94548) >> 16;
			zy = longint'(zyu);
			m = exp2_q16(zy, ip);
			q = g * m;
			if (ip < 30) begin
				sh = 30 - ip;
				c = (sh >= 64) ? 64'd0 : (q >> sh);
			end else begin
				sh = ip - 30;
				if (q == 0)
					c = 0;
				else if (sh >= 48 || q > (SAT48 >> sh))
					c = SAT48;
				else
					c = q << sh;
			end
			if (c > SAT48)
				c = SAT48;
			if (burn_cnt < burn_len) begin
				burn_cnt++;
			end else begin
				e.valid = 1'b1;
				if (c > ceiling) begin
					ceiling = c;
					e.raised = 1'b1;
				end
				if (ceiling == 0) begin
					e.score = 16'd25600;
				end else begin
					cc = c;
					ce = ceiling;
					while (ce >= (64'd1 << 32)) begin
						cc >>= 1;
						ce >>= 1;
					end
					rq = (cc << 16) / ce;
					e.score = 16'((rq * rq * 64'd25600) >> 32);
				end
			end
			expected_scores.push_back(e);
		endfunction

		function void check_score(score_t got);
			score_t e;
			if (expected_scores.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected score: score=%0d valid=%0b raised=%0b",
						got.score, got.valid, got.raised);
				return;
			end
			e = expected_scores.pop_front();
			if (got.score !== e.score || got.valid !== e.valid || got.raised !== e.raised) begin
				mismatches++;
				if (mismatches <= 10)
					$display("score mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
						e.score, e.valid, e.raised, got.score, got.valid, got.raised);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_BURN_IN;
	logic [15:0] cfg_data = '0;

	logic calm = 1'b0;
	logic hold = 1'b0;
	logic hold_go = 1'b0;

	aq_score_tracker sb = new();

	gas_air_quality_score uut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_score('{m_tdata, m_tuser[0], m_tuser[1]});
		m_tready <= !hold && (calm || $urandom_range(99) >= 29);
	end

	// long receiver stall so the block backs up
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold <= 1'b1;
		repeat (4000) @(posedge clk);
		hold <= 1'b0;
	end

	function automatic reading_t mk(int g, int h, int t);
		reading_t rd;
		rd.gas = 24'(g);
		rd.hum = 17'(h);
		rd.temp = 15'(t);
		return rd;
	endfunction

	function automatic reading_t rand_reading();
		if ($urandom_range(99) < 80)
			return mk($urandom_range(24'hFFFFFF), $urandom_range(100000),
				int'($urandom_range(12500)) - 4000);
		return mk($urandom, $urandom, $urandom);
	endfunction

	task automatic send(reading_t rd);
		s_tvalid <= 1'b1;
		s_tdata <= {rd.temp, rd.hum, rd.gas};
		do @(posedge clk); while (!s_tready);
		sb.note_reading(rd);
		if (!calm && $urandom_range(99) < 29) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_scores.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic cfg_write(logic idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic send_random(int cnt);
		for (int i = 0; i < cnt; i++)
			send(rand_reading());
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset defaults: burn-in then scoring
		send_random(30);
		drain();

		cfg_write(REG_BURN_IN, 16'd0);
		cfg_write(REG_GAIN, 16'd1966);
		send(mk(0, 0, 0));
		send(mk(0, 50000, 2500));
		send(mk(24'hFFFFFF, 100000, 8500));
		send(mk(24'hFFFFFF, 0, -4000));
		send(mk(1, 100000, -4000));
		send(mk(24'hFFFFFF, 131071, 16383));
		send(mk(24'hFFFFFF, 131071, -16384));
		send(mk(12345, 0, -16384));
		send(mk(100000, 45000, 2200));
		send(mk(99999, 45000, 2200));
		send(mk(200000, 45000, 2200));
		send(mk(24'hAAAAAA, 17'h15555, 15'h2AAA));
		send(mk(24'h555555, 17'h0AAAA, 15'h5555));
		send(mk(24'hFFFFFF, 100000, 8500));
		drain();

		cfg_write(REG_GAIN, 16'd65535);
		send(mk(24'hFFFFFF, 131071, 16383));
		send(mk(5000, 100000, 8500));
		send(mk(0, 131071, 16383));
		send(mk(1, 100000, 8500));
		drain();

		cfg_write(REG_GAIN, 16'd1966);
		hold_go <= 1'b1;
		send_random(100);
		calm <= 1'b1;
		send_random(80);
		calm <= 1'b0;
		send_random(120);
		drain();

		cfg_write(REG_BURN_IN, 16'd255);
		cfg_write(REG_GAIN, 16'd0);
		send_random(260);
		drain();

		// burn-in length now below the count
		cfg_write(REG_BURN_IN, 16'd3);
		cfg_write(REG_GAIN, 16'd65535);
		send_random(100);
		drain();

		cfg_write(REG_BURN_IN, 16'($urandom_range(255)));
		cfg_write(REG_GAIN, 16'($urandom_range(4000)));
		send_random(200);
		drain();

		if (sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
